[design/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator: field widths,
// register indexes, command codes, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

	// Field and register widths
	localparam int PAGE_W     = 16;
	localparam int TOTAL_W    = 20;
	localparam int PIECE_W    = 16;
	localparam int PID_IN_W   = 10;
	localparam int FREE_W     = 7;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 1;

	// Divider operand widths
	localparam int DIV_NUM_W = TOTAL_W;
	localparam int DIV_DEN_W = PAGE_W;

	// Parameter defaults
	localparam int FRAME_COUNT_DEF = 64;
	localparam int PID_WIDTH_DEF   = 10;

	// Register reset values
	localparam logic [PAGE_W-1:0]  PAGE_RESET  = 16'd4;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 20'd256;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MEM = 1'b1;

	// Command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_PDIV,
		ST_CHECK,
		ST_ALLOC,
		ST_FREE,
		ST_REPLY_OK,
		ST_REPLY_FAIL,
		ST_RECALC,
		ST_USABLE,
		ST_COUNT
	} pfa_state_t;

	// Frame table sweep kinds
	typedef enum logic [1:0] {
		SCAN_CLEAR,
		SCAN_COUNT,
		SCAN_FREE,
		SCAN_ALLOC
	} pfa_scan_t;

	// Controller to datapath
	typedef struct packed {
		logic      latch_item;
		logic      div_start;
		logic      div_usable;
		logic      usable_load;
		logic      pend_add;
		logic      pend_clear;
		logic      alloc_commit;
		logic      scan_start;
		logic      scan_stop;
		pfa_scan_t scan_mode;
		logic      post;
		logic      post_ok;
	} pfa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic scan_done;
		logic item_free;
		logic item_last;
		logic fits;
	} pfa_stat_t;

endpackage

[design/pfa_div.sv]
// ----------------------------------------------------------------------------
// pfa_div
// Restoring divider, one quotient bit per cycle. Used both for the page count
// of a piece and for the usable frame count after a register write.
// ----------------------------------------------------------------------------
module pfa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [pfa_pkg::DIV_NUM_W-1:0]  num,
	input  logic [pfa_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [pfa_pkg::DIV_NUM_W-1:0]  quot,
	output logic                           rem_nz
);
	import pfa_pkg::*;

	localparam int StepW = $clog2(DIV_NUM_W);
	localparam logic [StepW-1:0] LastStep = StepW'(DIV_NUM_W - 1);

	logic                 run_q;
	logic                 done_q;
	logic [StepW-1:0]     step_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	// Shift the next numerator bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == LastStep) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Advance quotient and remainder
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
		end
	end

	assign done   = done_q;
	assign quot   = quo_q;
	assign rem_nz = (rem_q != '0);

endmodule

[design/pfa_dp.sv]
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: configuration registers, divider, page accumulator, free and
// usable counts, the frame table memories and the two-stage table sweep.
// ----------------------------------------------------------------------------
module pfa_dp #(
	parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF,
	parameter int PID_WIDTH   = pfa_pkg::PID_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pfa_pkg::pfa_cmd_t               cmd,
	output pfa_pkg::pfa_stat_t              stat,
	input  logic                            cfg_write,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            command,
	input  logic [pfa_pkg::PID_IN_W-1:0]    proc_id,
	input  logic [pfa_pkg::PIECE_W-1:0]     piece_size_kb,
	input  logic                            last_piece,
	output logic                            done,
	output logic                            success,
	output logic [pfa_pkg::FREE_W-1:0]      free_frames
);
	import pfa_pkg::*;

	localparam int AW  = $clog2(FRAME_COUNT);
	localparam int CW  = $clog2(FRAME_COUNT + 2);
	localparam int CAP = FRAME_COUNT + 1;
	localparam logic [AW-1:0]        LastAddr  = AW'(FRAME_COUNT - 1);
	localparam logic [CW-1:0]        CapCnt    = CW'(CAP);
	localparam logic [CW-1:0]        FullCnt   = CW'(FRAME_COUNT);
	localparam logic [DIV_NUM_W-1:0] CapWide   = DIV_NUM_W'(CAP);
	localparam logic [DIV_NUM_W-1:0] FullWide  = DIV_NUM_W'(FRAME_COUNT);

	// Configuration and item registers
	logic [PAGE_W-1:0]    page_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [PAGE_W-1:0]    eff_page;
	logic                 cmd_q;
	logic                 last_q;
	logic [PID_WIDTH-1:0] pid_q;
	logic [PIECE_W-1:0]   piece_q;

	// Divider
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_NUM_W-1:0] div_quot;
	logic                 div_rem_nz;
	logic [DIV_NUM_W-1:0] pages;
	logic [CW-1:0]        pages_clamp;
	logic [CW:0]          pend_sum;

	// Counts
	logic [CW-1:0] usable_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] pend_q;
	logic [CW-1:0] need_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;

	// Sweep
	pfa_scan_t            mode_q;
	logic                 issue_q;
	logic [AW-1:0]        ptr_q;
	logic                 v_s1;
	logic [AW-1:0]        addr_s1;
	logic                 busy_s1;
	logic [PID_WIDTH-1:0] owner_s1;
	logic                 in_range;
	logic                 hit;
	logic                 take;
	logic                 inc;
	logic                 busy_we;
	logic                 busy_wdata;
	logic                 owner_we;
	logic                 scan_end;

	// Frame table
	logic                 busy_mem  [FRAME_COUNT];
	logic [PID_WIDTH-1:0] owner_mem [FRAME_COUNT];

	// Result word
	logic              done_q;
	logic              success_q;
	logic [FREE_W-1:0] frames_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= PAGE_RESET;
			total_q <= TOTAL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PAGE_SIZE: page_q  <= cfg_data[PAGE_W-1:0];
				REG_TOTAL_MEM: total_q <= cfg_data[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	// A page size of zero counts as one kilobyte
	assign eff_page = (page_q == '0) ? PAGE_W'(1) : page_q;

	// Capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			cmd_q   <= command;
			last_q  <= last_piece;
			pid_q   <= PID_WIDTH'(proc_id);
			piece_q <= piece_size_kb;
		end
	end

	assign div_num = cmd.div_usable ? total_q : DIV_NUM_W'(piece_q);

	pfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_start),
		.num    (div_num),
		.den    (eff_page),
		.done   (div_done),
		.quot   (div_quot),
		.rem_nz (div_rem_nz)
	);

	// Round the page count up, clamp, then saturate the accumulator
	assign pages       = div_quot + DIV_NUM_W'(div_rem_nz);
	assign pages_clamp = (pages > CapWide) ? CapCnt : CW'(pages);
	assign pend_sum    = {1'b0, pend_q} + {1'b0, pages_clamp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd.pend_clear || cmd.alloc_commit) begin
			pend_q <= '0;
		end else if (cmd.pend_add) begin
			pend_q <= (pend_sum > {1'b0, CapCnt}) ? CapCnt : pend_sum[CW-1:0];
		end
	end

	// Usable frames, capped at the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '0;
		end else if (cmd.usable_load) begin
			usable_q <= (div_quot > FullWide) ? FullCnt : CW'(div_quot);
		end
	end

	// Sweep stage one: classify the frame read back from the table
	assign in_range = CW'(addr_s1) < usable_q;
	assign hit      = busy_s1 && (owner_s1 == pid_q);
	assign take     = in_range && !busy_s1 && (need_q != '0);
	assign scan_end = v_s1 && (addr_s1 == LastAddr);

	always_comb begin
		busy_we    = 1'b0;
		busy_wdata = 1'b0;
		owner_we   = 1'b0;
		inc        = 1'b0;
		case (mode_q)
			SCAN_CLEAR: begin
				busy_we = v_s1;
			end
			SCAN_COUNT: begin
				inc = v_s1 && in_range && !busy_s1;
			end
			SCAN_FREE: begin
				busy_we = v_s1 && hit;
				inc     = v_s1 && in_range && (!busy_s1 || hit);
			end
			SCAN_ALLOC: begin
				busy_we    = v_s1 && take;
				busy_wdata = 1'b1;
				owner_we   = v_s1 && take;
			end
			default: ;
		endcase
	end

	assign cnt_next = cnt_q + CW'(inc);

	// Sweep stage zero: walk the address, one frame a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= SCAN_CLEAR;
			issue_q <= 1'b1;
			ptr_q   <= '0;
			v_s1    <= 1'b0;
			cnt_q   <= '0;
		end else if (cmd.scan_start) begin
			mode_q  <= cmd.scan_mode;
			issue_q <= 1'b1;
			ptr_q   <= '0;
			v_s1    <= 1'b0;
			cnt_q   <= '0;
		end else if (cmd.scan_stop) begin
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			v_s1  <= issue_q;
			cnt_q <= cnt_next;
			if (issue_q) begin
				ptr_q <= ptr_q + 1'b1;
				if (ptr_q == LastAddr) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
	end

	// Busy flags: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (busy_we) begin
			busy_mem[addr_s1] <= busy_wdata;
		end
		busy_s1 <= busy_mem[ptr_q];
	end

	// Owner ids: written on allocation only
	always_ff @(posedge clk) begin
		if (owner_we) begin
			owner_mem[addr_s1] <= pid_q;
		end
		owner_s1 <= owner_mem[ptr_q];
	end

	// Free count: drop on a granted request, reload at the end of a count or free sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (cmd.alloc_commit) begin
			free_q <= free_q - pend_q;
		end else if (scan_end && (mode_q == SCAN_COUNT || mode_q == SCAN_FREE)) begin
			free_q <= cnt_next;
		end
	end

	// Frames still to hand out during an allocation sweep
	always_ff @(posedge clk) begin
		if (cmd.alloc_commit) begin
			need_q <= pend_q;
		end else if (owner_we) begin
			need_q <= need_q - 1'b1;
		end
	end

	// Result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.post;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			success_q <= cmd.post_ok;
			frames_q  <= FREE_W'(free_q);
		end
	end

	assign done        = done_q;
	assign success     = success_q;
	assign free_frames = frames_q;

	assign stat.div_done  = div_done;
	assign stat.scan_done = scan_end;
	assign stat.item_free = (cmd_q == CMD_FREE);
	assign stat.item_last = last_q;
	assign stat.fits      = (pend_q <= free_q);

	// Accumulator never passes its saturation value
	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CapCnt)
		else $error("page accumulator above saturation value");

	// A request is granted only when enough frames are free
	a_commit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_commit |-> (pend_q <= free_q))
		else $error("allocation committed beyond free count");

	// An allocation sweep hands out every frame it was asked for
	a_alloc_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_end && mode_q == SCAN_ALLOC) |=> (need_q == '0))
		else $error("allocation sweep ended with frames still owed");

	// A result word lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

endmodule

[design/pfa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfa_ctrl
// Controller: sequences clearing, recalculation after register writes, piece
// division, the fit check, the table sweeps and the result word.
// ----------------------------------------------------------------------------
module pfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_write,
	input  pfa_pkg::pfa_stat_t stat,
	output pfa_pkg::pfa_cmd_t  cmd,
	output logic               busy
);
	import pfa_pkg::*;

	pfa_state_t state_q;
	pfa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.scan_done) state_d = ST_RECALC;
			end
			ST_IDLE: begin
				if (cfg_write) state_d = ST_RECALC;
				else if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = stat.item_free ? ST_FREE : ST_PDIV;
			end
			ST_PDIV: begin
				if (stat.div_done) state_d = stat.item_last ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				state_d = stat.fits ? ST_ALLOC : ST_REPLY_FAIL;
			end
			ST_ALLOC, ST_FREE: begin
				if (stat.scan_done) state_d = ST_REPLY_OK;
			end
			ST_REPLY_OK, ST_REPLY_FAIL: begin
				state_d = ST_IDLE;
			end
			ST_RECALC: begin
				if (!cfg_write) state_d = ST_USABLE;
			end
			ST_USABLE: begin
				if (cfg_write) state_d = ST_RECALC;
				else if (stat.div_done) state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (cfg_write) state_d = ST_RECALC;
				else if (stat.scan_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (!cfg_write && start) cmd.latch_item = 1'b1;
			end
			ST_DECODE: begin
				if (stat.item_free) begin
					cmd.pend_clear = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SCAN_FREE;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_PDIV: begin
				cmd.pend_add = stat.div_done;
			end
			ST_CHECK: begin
				if (stat.fits) begin
					cmd.alloc_commit = 1'b1;
					cmd.scan_start   = 1'b1;
					cmd.scan_mode    = SCAN_ALLOC;
				end else begin
					cmd.pend_clear = 1'b1;
				end
			end
			ST_REPLY_OK: begin
				cmd.post    = 1'b1;
				cmd.post_ok = 1'b1;
			end
			ST_REPLY_FAIL: begin
				cmd.post = 1'b1;
			end
			ST_RECALC: begin
				if (!cfg_write) begin
					cmd.div_start  = 1'b1;
					cmd.div_usable = 1'b1;
				end
			end
			ST_USABLE: begin
				if (!cfg_write && stat.div_done) begin
					cmd.usable_load = 1'b1;
					cmd.scan_start  = 1'b1;
					cmd.scan_mode   = SCAN_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.scan_stop = cfg_write;
			end
			default: ;
		endcase
	end

	// Hold off new words while working or while a register is written
	assign busy = (state_q != ST_IDLE) || cfg_write;

endmodule

[design/page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator
// First-fit page frame allocator. Keeps an owner table of frames, sums the
// page counts of the pieces of a request and grants the lowest free frames,
// or releases every frame of a process on a free command.
//
//   channel  signals                                         timing
//   item     start, busy, command, proc_id,                  taken on start & !busy
//            piece_size_kb, last_piece
//   result   done, success, free_frames                      one cycle at done
//   config   cfg_write, cfg_index, cfg_data                  taken on cfg_write
//
// A piece that is not last waits on the one-bit-a-cycle divider (20 steps)
// before the next word is taken. A last piece adds a fit check and, when
// granted, a sweep over the table memory port; a refused one goes straight
// to its result word.
// A free sweeps the whole table, one table read per frame.
// A register write keeps busy high, the write cycle included, while the
// usable count is divided out and the free frames are recounted.
// After reset a clearing pass empties the table, followed by that same
// recount. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
	parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF,
	parameter int PID_WIDTH   = pfa_pkg::PID_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            command,
	input  logic [pfa_pkg::PID_IN_W-1:0]    proc_id,
	input  logic [pfa_pkg::PIECE_W-1:0]     piece_size_kb,
	input  logic                            last_piece,
	output logic                            done,
	output logic                            success,
	output logic [pfa_pkg::FREE_W-1:0]      free_frames,
	input  logic                            cfg_write,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pfa_pkg::*;

	pfa_cmd_t  cmd;
	pfa_stat_t stat;

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_write (cfg_write),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	pfa_dp #(
		.FRAME_COUNT (FRAME_COUNT),
		.PID_WIDTH   (PID_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.proc_id       (proc_id),
		.piece_size_kb (piece_size_kb),
		.last_piece    (last_piece),
		.done          (done),
		.success       (success),
		.free_frames   (free_frames)
	);

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit page frame allocator. A directed
// table covers reset values, field extremes, accumulator saturation, empty,
// mixed-id and interrupted requests and a full table. Random request runs
// then follow under several register settings, page size zero and zero
// usable frames among them. A local model of the frame table predicts each
// result word not given by a directed row; the monitor checks all in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import pfa_pkg::*;

	localparam int FRAMES         = FRAME_COUNT_DEF;
	localparam int SETTLE_CYCLES  = FRAMES + 30;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic              ok;
		logic [FREE_W-1:0] frames;
	} grant_t;

	typedef struct packed {
		logic                cmd;
		logic [PID_IN_W-1:0] pid;
		logic [PIECE_W-1:0]  piece;
		logic                last;
		logic                typed;
		logic                ok;
		logic [FREE_W-1:0]   frames;
	} stim_row_t;

	// DUT signals, known from time zero
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  start         = 1'b0;
	logic                  busy;
	logic                  command       = CMD_ALLOC;
	logic [PID_IN_W-1:0]   proc_id       = '0;
	logic [PIECE_W-1:0]    piece_size_kb = '0;
	logic                  last_piece    = 1'b0;
	logic                  done;
	logic                  success;
	logic [FREE_W-1:0]     free_frames;
	logic                  cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_PAGE_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// Model of the frame table
	logic [PAGE_W-1:0]   page_reg  = PAGE_RESET;
	logic [TOTAL_W-1:0]  total_reg = TOTAL_RESET;
	logic [PID_IN_W-1:0] owner_of [FRAMES];
	bit                  held     [FRAMES];
	int unsigned         usable_cnt;
	int unsigned         free_left;
	int unsigned         pages_owed;

	grant_t    grant_q [$];
	stim_row_t dir_rows [$];

	int fails        = 0;
	int results_seen = 0;
	int items_sent   = 0;
	int settings     = 1;
	int burst_left   = 0;
	int stall_cnt    = 0;

	page_frame_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.proc_id       (proc_id),
		.piece_size_kb (piece_size_kb),
		.last_piece    (last_piece),
		.done          (done),
		.success       (success),
		.free_frames   (free_frames),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// A zero page size counts as one kilobyte
	function automatic int unsigned page_div();
		return (page_reg == '0) ? 1 : int'(page_reg);
	endfunction

	function automatic void recount_free();
		int unsigned i;
		free_left = 0;
		for (i = 0; i < usable_cnt; i++)
			if (!held[i])
				free_left++;
	endfunction

	// Recompute the usable frame count and the free count after a register change
	function automatic void retune();
		int unsigned u;
		u = int'(total_reg) / page_div();
		usable_cnt = (u > FRAMES) ? FRAMES : u;
		recount_free();
	endfunction

	// Advance the frame table model by one request word
	function automatic void predict_grant(input logic cmd, input logic [PID_IN_W-1:0] pid,
			input logic [PIECE_W-1:0] piece, input logic last,
			output bit gives, output grant_t g);
		int unsigned i;
		int unsigned ps;
		int unsigned sz;
		int unsigned pages;
		int unsigned sum;
		int unsigned need;
		gives = 1'b0;
		g = '0;
		if (cmd == CMD_FREE) begin
			// drop any partial request, release every frame of the process
			pages_owed = 0;
			for (i = 0; i < FRAMES; i++)
				if (held[i] && owner_of[i] == pid)
					held[i] = 1'b0;
			recount_free();
			gives = 1'b1;
			g.ok = 1'b1;
			g.frames = free_left[FREE_W-1:0];
		end else begin
			ps = page_div();
			sz = 32'(piece);
			pages = (sz + ps - 1) / ps;
			sum = pages_owed + pages;
			pages_owed = (sum > FRAMES + 1) ? FRAMES + 1 : sum;
			if (last) begin
				gives = 1'b1;
				if (pages_owed > free_left) begin
					g.ok = 1'b0;
				end else begin
					// first fit over the usable frames
					need = pages_owed;
					for (i = 0; i < usable_cnt && need > 0; i++) begin
						if (!held[i]) begin
							held[i] = 1'b1;
							owner_of[i] = pid;
							need--;
						end
					end
					free_left -= pages_owed;
					g.ok = 1'b1;
				end
				pages_owed = 0;
				g.frames = free_left[FREE_W-1:0];
			end
		end
	endfunction

	function automatic stim_row_t mk_row(input logic c, input logic [PID_IN_W-1:0] p,
			input logic [PIECE_W-1:0] s, input logic l, input logic t,
			input logic ok, input logic [FREE_W-1:0] ff);
		stim_row_t r;
		r.cmd = c;
		r.pid = p;
		r.piece = s;
		r.last = l;
		r.typed = t;
		r.ok = ok;
		r.frames = ff;
		return r;
	endfunction

	// Drive one request word in bursts with random gaps, then log its outcome
	task automatic send_word(input logic c, input logic [PID_IN_W-1:0] p,
			input logic [PIECE_W-1:0] s, input logic l, input bit typed,
			input grant_t typed_g);
		bit     gives;
		grant_t g;
		int     gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start         <= 1'b1;
		command       <= c;
		proc_id       <= p;
		piece_size_kb <= s;
		last_piece    <= l;
		do @(posedge clk); while (busy);
		items_sent++;
		predict_grant(c, p, s, l, gives, g);
		if (gives)
			grant_q.push_back(typed ? typed_g : g);
	endtask

	// Drain every outstanding result and let a trailing piece finish
	task automatic quiesce();
		start <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_PAGE_SIZE)
			page_reg = val[PAGE_W-1:0];
		else
			total_reg = val[TOTAL_W-1:0];
		retune();
		repeat (2) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// One register setting followed by random request traffic
	task automatic run_phase(input logic [PAGE_W-1:0] page, input logic [TOTAL_W-1:0] total,
			input int count);
		logic [PID_IN_W-1:0] pool [4];
		int                  n;
		int                  k;
		int                  j;
		int                  pieces;
		int unsigned         cap;
		logic [PID_IN_W-1:0] pid;
		logic [PIECE_W-1:0]  sz;
		quiesce();
		write_reg(REG_PAGE_SIZE, CFG_DATA_W'(page));
		write_reg(REG_TOTAL_MEM, total);
		settings++;
		for (k = 0; k < 4; k++)
			pool[k] = PID_IN_W'($urandom_range(0, 1023));
		cap = page_div() * 3;
		if (cap > 65535)
			cap = 65535;
		n = 0;
		while (n < count) begin
			k = $urandom_range(0, 9);
			if (k < 7) begin
				// well-formed request: a few pieces, the final one marked last
				pieces = $urandom_range(1, 4);
				for (j = 0; j < pieces; j++) begin
					pid = ($urandom_range(0, 7) == 0) ? PID_IN_W'($urandom_range(0, 1023))
						: pool[$urandom_range(0, 3)];
					sz = ($urandom_range(0, 15) == 0) ? PIECE_W'($urandom_range(0, 65535))
						: PIECE_W'($urandom_range(0, cap));
					send_word(CMD_ALLOC, pid, sz, (j == pieces - 1), 1'b0, '0);
					n++;
				end
			end else if (k < 9) begin
				send_word(CMD_FREE, pool[$urandom_range(0, 3)],
					PIECE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
					1'b0, '0);
				n++;
			end else begin
				// noise: any field value at all
				send_word(1'($urandom_range(0, 1)), PID_IN_W'($urandom_range(0, 1023)),
					PIECE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
					1'b0, '0);
				n++;
			end
		end
		// close the phase with a free so no partial request is left pending
		send_word(CMD_FREE, pool[0], PIECE_W'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	// Check each result word against the oldest prediction
	always @(posedge clk) begin : check_results
		grant_t want;
		if (arst_n && done) begin
			if (grant_q.size() == 0) begin
				$error("unexpected result word: success %0d, free_frames %0d",
					success, free_frames);
				fails++;
			end else begin
				want = grant_q.pop_front();
				results_seen++;
				if (success !== want.ok) begin
					$error("success: expected %0d, got %0d", want.ok, success);
					fails++;
				end
				if (free_frames !== want.frames) begin
					$error("free_frames: expected %0d, got %0d", want.frames, free_frames);
					fails++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_write)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int        i;
		stim_row_t r;
		grant_t    tg;
		for (i = 0; i < FRAMES; i++) begin
			held[i] = 1'b0;
			owner_of[i] = '0;
		end
		pages_owed = 0;
		retune();

		// Directed table under the reset registers (64 frames of 4 KB)
		dir_rows.push_back(mk_row(CMD_FREE,  10'd0,    16'd0,     1'b0, 1'b1, 1'b1, 7'd64));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd5,    16'd0,     1'b1, 1'b1, 1'b1, 7'd64));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd1023, 16'd65535, 1'b1, 1'b1, 1'b0, 7'd64));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd3,    16'd4,     1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd3,    16'd5,     1'b1, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd7,    16'd1,     1'b1, 1'b0, 1'b0, 7'd0));
		// mixed ids: the id on the last piece takes the frames
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd9,    16'd8,     1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd10,   16'd4,     1'b1, 1'b0, 1'b0, 7'd0));
		// free arriving while a request is still pending
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd11,   16'd40,    1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd3,    16'd65535, 1'b1, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd12,   16'd16,    1'b1, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd9,    16'd0,     1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd10,   16'd0,     1'b0, 1'b0, 1'b0, 7'd0));
		// accumulator saturation over two pieces
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd1023, 16'd65535, 1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd1023, 16'd1,     1'b1, 1'b0, 1'b0, 7'd0));
		// fill the table to the last frame
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd512,  16'd224,   1'b1, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd512,  16'd16,    1'b1, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd1,    16'd12,    1'b1, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_ALLOC, 10'd682,  16'd1,     1'b1, 1'b1, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd512,  16'd0,     1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd1023, 16'd0,     1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd1,    16'd0,     1'b0, 1'b0, 1'b0, 7'd0));
		dir_rows.push_back(mk_row(CMD_FREE,  10'd341,  16'd0,     1'b0, 1'b0, 1'b0, 7'd0));

		// Hold reset, then wait out the clearing pass
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		while (busy) @(posedge clk);

		for (i = 0; i < dir_rows.size(); i++) begin
			r = dir_rows[i];
			tg.ok = r.ok;
			tg.frames = r.frames;
			send_word(r.cmd, r.pid, r.piece, r.last, r.typed, tg);
		end

		// Random traffic under a spread of register settings
		run_phase(16'd1,     20'd1048575, 150);
		run_phase(16'd65535, 20'd1,       120);
		run_phase(16'd16,    20'd500,     150);
		run_phase(16'd0,     20'd40,      150);
		run_phase(16'd65535, 20'd1048575, 150);
		run_phase(16'd4,     20'd256,     150);
		run_phase(16'd1,     20'd1,       120);
		quiesce();

		$display("Summary: %0d request words sent over %0d register settings,",
			items_sent, settings);
		$display("         %0d result words checked, %0d mismatches", results_seen, fails);
		if (fails == 0 && grant_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
design/pfa_pkg.sv
design/pfa_div.sv
design/pfa_dp.sv
design/pfa_ctrl.sv
design/page_frame_allocator.sv
tb/testbench.sv
